FILE: rtl/svdp_pkg.sv
// Package for the store vector dependence predictor.
// Holds sizes, request codes, controller states and the table write struct.
// No dependencies.
package svdp_pkg;

  localparam int unsigned TableEntries = 32;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned VectorBits   = 32;
  localparam int unsigned OffW         = $clog2(VectorBits);
  localparam int unsigned CntW         = 33;
  localparam int unsigned AddrW        = 3;
  localparam logic [31:0] ClearPeriodReset = 32'd250000;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_VIOLATION = 2'd1,
    REQ_CHECK     = 2'd2,
    REQ_NONE      = 2'd3
  } req_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // write-back request from the controller to the table
  typedef struct packed {
    logic                  wr_en;
    logic                  wipe;
    logic [IdxW-1:0]       idx;
    logic [VectorBits-1:0] data;
  } tbl_wr_t;

endpackage

FILE: rtl/svdp_cfg.sv
// Configuration register block with an APB-style port.
// Holds the wipe period register; depends on svdp_pkg.
module svdp_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [svdp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output logic [31:0]              wipe_period_o
);
  import svdp_pkg::*;

  logic [31:0] wipe_period_q, wipe_period_d;
  logic        reg_sel;

  // register 0 sits at byte address 0
  assign reg_sel = (paddr[2] == 1'b0);

  always_comb begin
    wipe_period_d = wipe_period_q;
    if (psel && penable && pwrite && reg_sel) begin
      wipe_period_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_period_q <= ClearPeriodReset;
    end else begin
      wipe_period_q <= wipe_period_d;
    end
  end

  assign prdata        = reg_sel ? wipe_period_q : 32'd0;
  assign pready        = 1'b1;
  assign wipe_period_o = wipe_period_q;

endmodule

FILE: rtl/svdp_table.sv
// Dependence table: synchronous memory of store vectors plus per-entry valid bits.
// Read data is registered; invalid entries read as zero. Depends on svdp_pkg.
module svdp_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [svdp_pkg::IdxW-1:0]           rd_idx_i,
  output logic [svdp_pkg::VectorBits-1:0]     rd_data_o,
  input  svdp_pkg::tbl_wr_t                   wr_i
);
  import svdp_pkg::*;

  logic [VectorBits-1:0]   mem [TableEntries];
  logic [TableEntries-1:0] valid_q, valid_d;
  logic [VectorBits-1:0]   rd_data_q;
  logic                    rd_valid_q;

  // memory write port
  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  // valid bits: wipe clears all, a write marks its entry
  always_comb begin
    valid_d = valid_q;
    if (wr_i.wipe) begin
      valid_d = '0;
    end else if (wr_i.wr_en) begin
      valid_d[wr_i.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: rtl/store_vector_dependence_predictor.sv
// Store vector dependence predictor, top level.
// A result word is registered at the edge after the one that accepts its request.
// A new request word is taken only once the previous one is through: the table read in
// ST_IDLE is followed by the update and write-back in ST_EXEC on the single table memory.
// Reset: table valid bits and the memop counter clear at once, the wipe period
// returns to 250000; no clearing pass. Depends on svdp_pkg, svdp_cfg, svdp_table.
module store_vector_dependence_predictor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [63:0]                load_pc_i,
  input  logic [7:0]                 sq_head_i,
  input  logic [7:0]                 sq_tail_i,
  input  logic [7:0]                 store_sq_index_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [31:0]                dep_mask_o,
  output logic                       offset_error_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [svdp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import svdp_pkg::*;

  state_e state_q, state_d;
  logic   accept, exec_en;

  logic [1:0]      req_q;
  logic [IdxW-1:0] idx_q;
  logic [7:0]      head_q, tail_q, sidx_q;

  logic [CntW-1:0] memop_cnt_q, memop_cnt_d, cnt_inc;
  logic [31:0]     wipe_period;

  logic [VectorBits-1:0] rd_data;
  tbl_wr_t               tbl_wr;

  logic        out_valid_q, out_valid_d;
  logic [31:0] dep_mask_q, dep_mask_d;
  logic        err_q, err_d;

  logic [7:0]            viol_off, chk_n;
  logic                  viol_err;
  logic [VectorBits-1:0] chk_lowmask;

  svdp_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .wipe_period_o (wipe_period)
  );

  svdp_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_idx_i  (load_pc_i[IdxW-1:0]),
    .rd_data_o (rd_data),
    .wr_i      (tbl_wr)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall_o = 1'b1;
    exec_en    = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = out_valid_q && out_stall_i;
      ST_EXEC: exec_en    = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture alongside the table read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      idx_q  <= load_pc_i[IdxW-1:0];
      head_q <= sq_head_i;
      tail_q <= sq_tail_i;
      sidx_q <= store_sq_index_i;
    end
  end

  // violation offset and range check
  assign viol_off = tail_q - sidx_q;
  assign viol_err = (sidx_q > tail_q) || (viol_off >= 8'(VectorBits));

  // check mask over the stores in the queue
  assign chk_n       = tail_q - head_q;
  assign chk_lowmask = (chk_n >= 8'(VectorBits)) ? '1 :
                       ~({VectorBits{1'b1}} << chk_n[OffW-1:0]);

  assign cnt_inc = memop_cnt_q + CntW'(1);

  // execute: result, table write-back and wipe counter
  always_comb begin
    tbl_wr      = '0;
    tbl_wr.idx  = idx_q;
    tbl_wr.data = rd_data | (VectorBits'(1) << viol_off[OffW-1:0]);
    memop_cnt_d = memop_cnt_q;
    dep_mask_d  = dep_mask_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (exec_en) begin
      out_valid_d = 1'b1;
      dep_mask_d  = '0;
      err_d       = 1'b0;
      case (req_q)
        REQ_INSERT: begin
          if (cnt_inc > {1'b0, wipe_period}) begin
            memop_cnt_d = '0;
            tbl_wr.wipe = 1'b1;
          end else begin
            memop_cnt_d = cnt_inc;
          end
        end
        REQ_VIOLATION: begin
          if (viol_err) begin
            err_d = 1'b1;
          end else begin
            tbl_wr.wr_en = 1'b1;
          end
        end
        REQ_CHECK: begin
          if (head_q <= tail_q) begin
            dep_mask_d = 32'(rd_data & chk_lowmask);
          end
        end
        default: begin
          dep_mask_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memop_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      memop_cnt_q <= memop_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    dep_mask_q <= dep_mask_d;
    err_q      <= err_d;
  end

  assign out_valid_o    = out_valid_q;
  assign dep_mask_o     = dep_mask_q;
  assign offset_error_o = err_q;

endmodule

FILE: verif/svdp_dep_checker.sv
// Checker for the store vector dependence predictor: watches the request,
// result and register channels, predicts every result word and compares it.
// Depends on svdp_pkg.
module svdp_dep_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [63:0]                load_pc_i,
  input  logic [7:0]                 sq_head_i,
  input  logic [7:0]                 sq_tail_i,
  input  logic [7:0]                 store_sq_index_i,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic [31:0]                dep_mask_o,
  input  logic                       offset_error_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [svdp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  output int                         fail_cnt_o,
  output int                         pending_o,
  output int                         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import svdp_pkg::*;

  localparam logic [AddrW-1:0] ClearPeriodAddr = '0;

  typedef struct packed {
    logic [31:0] dep_mask;
    logic        offset_error;
  } dep_word_t;

  // shadow copy of the predictor state
  logic [VectorBits-1:0] dep_vectors [TableEntries];
  logic [CntW-1:0]       memop_cnt;
  logic [31:0]           wipe_period;
  dep_word_t             expected_dep_q [$];
  int                    fails;
  int                    checked;

  // updates the shadow table for one request word and returns its result word
  function automatic dep_word_t predict_dep_word(input req_e req, input logic [63:0] pc,
                                                 input logic [7:0] head, input logic [7:0] tail,
                                                 input logic [7:0] sidx);
    dep_word_t       res;
    logic [IdxW-1:0] idx;
    int              span;
    logic [63:0]     keep;
    res = '0;
    idx = pc[IdxW-1:0];
    case (req)
      REQ_INSERT: begin
        // memop count, wipe the whole table once past the period
        memop_cnt = memop_cnt + 1'b1;
        if (memop_cnt > {1'b0, wipe_period}) begin
          memop_cnt = '0;
          foreach (dep_vectors[i]) dep_vectors[i] = '0;
        end
      end
      REQ_VIOLATION: begin
        // offset below tail, out of range flags and leaves the table alone
        span = int'(tail) - int'(sidx);
        if (span < 0 || span >= int'(VectorBits)) begin
          res.offset_error = 1'b1;
        end else begin
          dep_vectors[idx][span] = 1'b1;
        end
      end
      REQ_CHECK: begin
        // only stores actually in the queue are reported
        if (head <= tail) begin
          span = int'(tail) - int'(head);
          if (span > int'(VectorBits)) span = int'(VectorBits);
          keep = (64'd1 << span) - 64'd1;
          res.dep_mask = 32'(dep_vectors[idx] & keep[VectorBits-1:0]);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dep_word_t want;
    if (!rst_ni) begin
      foreach (dep_vectors[i]) dep_vectors[i] = '0;
      memop_cnt   = '0;
      wipe_period = ClearPeriodReset;
      expected_dep_q.delete();
    end else begin
      // register writes and read-back
      if (psel && penable && pready && paddr == ClearPeriodAddr) begin
        if (pwrite) begin
          wipe_period = pwdata;
        end else if (prdata !== wipe_period) begin
          $error("wipe period read expected %0d got %0d", wipe_period, prdata);
          fails++;
        end
      end
      // result word against the oldest expectation
      if (out_valid_o && !out_stall_i) begin
        if (expected_dep_q.size() == 0) begin
          $error("result word with nothing expected: dep_mask %h offset_error %b",
                 dep_mask_o, offset_error_o);
          fails++;
        end else begin
          want = expected_dep_q.pop_front();
          checked++;
          if (dep_mask_o !== want.dep_mask) begin
            $error("dep_mask expected %h got %h", want.dep_mask, dep_mask_o);
            fails++;
          end
          if (offset_error_o !== want.offset_error) begin
            $error("offset_error expected %b got %b", want.offset_error, offset_error_o);
            fails++;
          end
        end
      end
      // request word, appended behind the older expectations
      if (in_valid_i && !in_stall_o) begin
        expected_dep_q.insert(expected_dep_q.size(),
                              predict_dep_word(req_e'(req_type_i), load_pc_i, sq_head_i,
                                               sq_tail_i, store_sq_index_i));
      end
    end
    fail_cnt_o <= fails;
    pending_o  <= expected_dep_q.size();
    checked_o  <= checked;
  end

endmodule

FILE: verif/store_vector_dependence_predictor_tb.sv
// Testbench top for the store vector dependence predictor: drives request
// words, wipe period writes and result stalls, and gives the verdict.
// Depends on svdp_pkg, store_vector_dependence_predictor and svdp_dep_checker.
module store_vector_dependence_predictor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svdp_pkg::*;

  localparam int unsigned CycleLimit      = 400000;
  localparam int unsigned PhaseWords      = 68;
  localparam logic [AddrW-1:0] ClearPeriodAddr = '0;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       req_type_i;
  logic [63:0]      load_pc_i;
  logic [7:0]       sq_head_i;
  logic [7:0]       sq_tail_i;
  logic [7:0]       store_sq_index_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [31:0]      dep_mask_o;
  logic             offset_error_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  bit idle_on;
  int stall_left;
  int cycle_cnt;
  int words_by_req [4];
  int settings_cnt;

  store_vector_dependence_predictor dut (.*);

  svdp_dep_checker u_checker (
    .*,
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt),
    .checked_o  (checked_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side stall bursts
  always @(posedge clk_i) begin
    if (idle_on && stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL store_vector_dependence_predictor");
      $finish;
    end
  end

  // one request word, held until accepted
  task automatic send_word(input req_e req, input logic [63:0] pc, input logic [7:0] head,
                           input logic [7:0] tail, input logic [7:0] sidx);
    in_valid_i       <= 1'b1;
    req_type_i       <= req;
    load_pc_i        <= pc;
    sq_head_i        <= head;
    sq_tail_i        <= tail;
    store_sq_index_i <= sidx;
    words_by_req[int'(req)]++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // setup and access phases on the register port, then a return to idle
  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and wait for every expected word, then let the pipe settle
  task automatic drain_results(input int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // mostly well-formed violations and checks on a few hot entries
  task automatic send_random_words(input int count);
    req_e        req;
    logic [63:0] pc;
    logic [7:0]  head;
    logic [7:0]  tail;
    logic [7:0]  sidx;
    int          roll;
    int          off;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      pc   = {$urandom, $urandom};
      if ($urandom_range(0, 9) < 7) pc[IdxW-1:0] = IdxW'($urandom_range(0, 7));
      head = 8'($urandom);
      tail = 8'($urandom);
      sidx = 8'($urandom);
      if (roll < 20) begin
        req = REQ_INSERT;
      end else if (roll < 55) begin
        req = REQ_VIOLATION;
        if ($urandom_range(0, 6) != 0) begin
          off  = $urandom_range(0, (tail < VectorBits) ? int'(tail) : int'(VectorBits) - 1);
          sidx = 8'(int'(tail) - off);
        end
      end else if (roll < 95) begin
        req = REQ_CHECK;
        if ($urandom_range(0, 4) != 0) head = 8'($urandom_range(0, tail));
      end else begin
        req = REQ_NONE;
      end
      if (idle_on && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      send_word(req, pc, head, tail, sidx);
    end
  endtask

  initial begin
    logic [31:0] periods [6];
    in_valid_i       <= 1'b0;
    req_type_i       <= REQ_NONE;
    load_pc_i        <= '0;
    sq_head_i        <= '0;
    sq_tail_i        <= '0;
    store_sq_index_i <= '0;
    out_stall_i      <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    rst_ni           <= 1'b0;
    idle_on          <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of the wipe period
    apb_access(1'b0, ClearPeriodAddr, '0);

    // directed: empty table, offset extremes, bad offsets, mask limits
    send_word(REQ_CHECK,     64'd0,            8'd0,   8'd0,   8'd0);
    send_word(REQ_VIOLATION, 64'd0,            8'd0,   8'd0,   8'd0);
    send_word(REQ_VIOLATION, 64'd0,            8'd0,   8'd31,  8'd0);
    send_word(REQ_VIOLATION, 64'd0,            8'd0,   8'd32,  8'd0);
    send_word(REQ_VIOLATION, 64'd0,            8'd0,   8'd0,   8'd1);
    send_word(REQ_VIOLATION, '1,               8'd255, 8'd255, 8'd255);
    send_word(REQ_VIOLATION, 64'd5,            8'd0,   8'd255, 8'd0);
    send_word(REQ_VIOLATION, 64'hFFFF_FFFF_FFFF_FFE0, 8'd0, 8'd200, 8'd190);
    send_word(REQ_CHECK,     64'd0,            8'd0,   8'd255, 8'd0);
    send_word(REQ_CHECK,     64'd0,            8'd0,   8'd31,  8'd0);
    send_word(REQ_CHECK,     64'd0,            8'd0,   8'd32,  8'd0);
    send_word(REQ_CHECK,     64'd0,            8'd5,   8'd4,   8'd0);
    send_word(REQ_CHECK,     64'd0,            8'd255, 8'd255, 8'd0);
    send_word(REQ_CHECK,     64'd0,            8'd0,   8'd1,   8'd0);
    send_word(REQ_CHECK,     '1,               8'd0,   8'd255, 8'd0);
    send_word(REQ_NONE,      '1,               8'd255, 8'd255, 8'd255);
    send_word(REQ_INSERT,    {$urandom, $urandom}, 8'd0, 8'd0, 8'd0);
    send_word(REQ_CHECK,     64'd32,           8'd100, 8'd140, 8'd0);
    drain_results(4);

    // random words under the reset period, then a sweep of periods
    idle_on <= 1'b1;
    send_random_words(40);
    drain_results(4);
    periods[0] = 32'd0;
    periods[1] = 32'd3;
    periods[2] = 32'hFFFF_FFFF;
    periods[3] = $urandom_range(1, 30);
    periods[4] = 32'd12;
    periods[5] = 32'd0;
    foreach (periods[p]) begin
      apb_access(1'b1, ClearPeriodAddr, periods[p]);
      apb_access(1'b0, ClearPeriodAddr, '0);
      settings_cnt++;
      // quiet stretch in the middle and for the closing phase
      idle_on <= (p != 2) && (p != 5);
      send_random_words(PhaseWords);
      drain_results(4);
    end

    drain_results(8);
    $display("covered %0d words: %0d inserts, %0d violations, %0d checks, %0d unused codes",
             words_by_req[0] + words_by_req[1] + words_by_req[2] + words_by_req[3],
             words_by_req[0], words_by_req[1], words_by_req[2], words_by_req[3]);
    $display("%0d result words compared across %0d wipe period settings",
             checked_cnt, settings_cnt);
    if (fail_cnt == 0) begin
      $display("PASS store_vector_dependence_predictor");
    end else begin
      $display("FAIL store_vector_dependence_predictor");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/svdp_pkg.sv
rtl/svdp_cfg.sv
rtl/svdp_table.sv
rtl/store_vector_dependence_predictor.sv
verif/svdp_dep_checker.sv
verif/store_vector_dependence_predictor_tb.sv
